// ----- src/fbpw_pkg.sv -----
// fbpw_pkg: register map, pixel format codes and pixel conversion functions
`timescale 1ns / 1ps

package fbpw_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_DEST_FORMAT      = 3'd0,
    REG_SOURCE_IS_RGB565 = 3'd1,
    REG_FRAME_WIDTH      = 3'd2,
    REG_FRAME_HEIGHT     = 3'd3,
    REG_ROW_STRIDE       = 3'd4,
    REG_VISIBLE_OFFSET   = 3'd5,
    REG_FRAME_BASE       = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    FMT_RGB565   = 2'd0,
    FMT_XRGB8888 = 2'd1,
    FMT_ARGB8888 = 2'd2
  } dest_format_t;

  localparam logic [31:0] ALPHA_MASK = 32'hff00_0000;
  localparam logic [31:0] COLOR_MASK = 32'h00ff_ffff;

  // argb8888 to rgb565 by truncation
  function automatic logic [15:0] pack_565(input logic [31:0] p);
    pack_565 = {p[23:19], p[15:10], p[7:3]};
  endfunction

  // rgb565 to 32 bits with high bits replicated into the low ones
  function automatic logic [31:0] widen_565(input logic [15:0] p, input logic with_alpha);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = p[15:11];
    g = p[10:5];
    b = p[4:0];
    widen_565 = (with_alpha ? ALPHA_MASK : 32'h0)
              | {8'h00, r, r[4:2], g, g[5:4], b, b[4:2]};
  endfunction

endpackage

// ----- src/framebuffer_pixel_writer.sv -----
// framebuffer_pixel_writer: pixel format conversion and framebuffer address generation
//
//   channel | direction | handshake                   | payload
//   in      | input     | in_valid / in_stall         | in_source_pixel
//   out     | output    | out_valid / out_stall       | out_write_address, out_write_data,
//           |           |                             | out_two_byte_write, out_row_last,
//           |           |                             | out_frame_last
//   cfg     | input     | apb write/read, pready high | registers at byte address 4*i
//
// one transaction per clock while the output is not stalled; a result appears in the cycle after its input is accepted
// throughput is set by the single result register; input stalls only while it is full and held
// synchronous active-low reset clears counters, row address, output valid and registers
// configuration takes effect at once; base and offset are picked up at the next frame start
`timescale 1ns / 1ps

module framebuffer_pixel_writer #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [31:0]                        in_source_pixel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        out_write_address,
  output logic [31:0]                        out_write_data,
  output logic                               out_two_byte_write,
  output logic                               out_row_last,
  output logic                               out_frame_last,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [fbpw_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [fbpw_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [fbpw_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  localparam int unsigned CNT_W = $clog2(MAX_DIMENSION);
  localparam int unsigned CMP_W = (CNT_W + 1 > 13) ? CNT_W + 1 : 13;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DIMENSION - 1);

  // configuration registers
  logic [1:0]  dest_format_r;
  logic        source_is_rgb565_r;
  logic [12:0] frame_width_r;
  logic [12:0] frame_height_r;
  logic [16:0] row_stride_r;
  logic [31:0] visible_offset_r;
  logic [31:0] frame_base_r;

  logic                  cfg_write;
  fbpw_pkg::reg_index_t  cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = fbpw_pkg::reg_index_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_format_r      <= fbpw_pkg::FMT_RGB565;
      source_is_rgb565_r <= 1'b0;
      frame_width_r      <= 13'd1;
      frame_height_r     <= 13'd1;
      row_stride_r       <= 17'd4;
      visible_offset_r   <= 32'd0;
      frame_base_r       <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_sel)
        fbpw_pkg::REG_DEST_FORMAT:      dest_format_r      <= cfg_pwdata[1:0];
        fbpw_pkg::REG_SOURCE_IS_RGB565: source_is_rgb565_r <= cfg_pwdata[0];
        fbpw_pkg::REG_FRAME_WIDTH:      frame_width_r      <= cfg_pwdata[12:0];
        fbpw_pkg::REG_FRAME_HEIGHT:     frame_height_r     <= cfg_pwdata[12:0];
        fbpw_pkg::REG_ROW_STRIDE:       row_stride_r       <= cfg_pwdata[16:0];
        fbpw_pkg::REG_VISIBLE_OFFSET:   visible_offset_r   <= cfg_pwdata;
        fbpw_pkg::REG_FRAME_BASE:       frame_base_r       <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      fbpw_pkg::REG_DEST_FORMAT:      cfg_prdata = {30'd0, dest_format_r};
      fbpw_pkg::REG_SOURCE_IS_RGB565: cfg_prdata = {31'd0, source_is_rgb565_r};
      fbpw_pkg::REG_FRAME_WIDTH:      cfg_prdata = {19'd0, frame_width_r};
      fbpw_pkg::REG_FRAME_HEIGHT:     cfg_prdata = {19'd0, frame_height_r};
      fbpw_pkg::REG_ROW_STRIDE:       cfg_prdata = {15'd0, row_stride_r};
      fbpw_pkg::REG_VISIBLE_OFFSET:   cfg_prdata = visible_offset_r;
      fbpw_pkg::REG_FRAME_BASE:       cfg_prdata = frame_base_r;
      default:                        cfg_prdata = '0;
    endcase
  end

  // position state
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [31:0]      row_addr_r, row_addr_nxt;

  // result register
  logic        out_valid_r;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_two_r;
  logic        out_row_last_r;
  logic        out_frame_last_r;

  logic        in_accept;
  logic        frame_start;
  logic        to565;
  logic        argb_out;
  logic        row_end;
  logic        frame_end;
  logic [31:0] base_off;
  logic [31:0] col_bytes;
  logic [31:0] row_start;
  logic [CMP_W-1:0] col_inc;
  logic [CMP_W-1:0] row_inc;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    to565       = (dest_format_r == fbpw_pkg::FMT_RGB565);
    argb_out    = dest_format_r[1];
    frame_start = (col_r == '0) && (row_r == '0);
    base_off    = frame_base_r + visible_offset_r;
    col_bytes   = to565 ? (32'(col_r) << 1) : (32'(col_r) << 2);
    row_start   = frame_start ? base_off : row_addr_r;
    out_addr_nxt = frame_start ? base_off : (row_addr_r + col_bytes);

    if (source_is_rgb565_r) begin
      out_data_nxt = to565 ? {16'd0, in_source_pixel[15:0]}
                           : fbpw_pkg::widen_565(in_source_pixel[15:0], argb_out);
    end else if (to565) begin
      out_data_nxt = {16'd0, fbpw_pkg::pack_565(in_source_pixel)};
    end else if (!argb_out) begin
      out_data_nxt = in_source_pixel & fbpw_pkg::COLOR_MASK;
    end else begin
      out_data_nxt = in_source_pixel;
    end

    // zero size acts as one, oversize saturates at the last count
    col_inc   = CMP_W'(col_r) + CMP_W'(1);
    row_inc   = CMP_W'(row_r) + CMP_W'(1);
    row_end   = (CMP_W'(frame_width_r) <= col_inc) || (col_r == CNT_LAST);
    frame_end = row_end && ((CMP_W'(frame_height_r) <= row_inc) || (row_r == CNT_LAST));

    col_nxt      = row_end ? '0 : col_r + CNT_W'(1);
    row_nxt      = row_r;
    row_addr_nxt = row_start;
    if (row_end) begin
      if (frame_end) begin
        row_nxt = '0;
      end else begin
        row_nxt      = row_r + CNT_W'(1);
        row_addr_nxt = row_start + 32'(row_stride_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      row_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        row_addr_r <= row_addr_nxt;
      end
      if (!in_stall) begin
        out_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_addr_r       <= out_addr_nxt;
      out_data_r       <= out_data_nxt;
      out_two_r        <= to565;
      out_row_last_r   <= row_end;
      out_frame_last_r <= frame_end;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_write_address  = out_addr_r;
  assign out_write_data     = out_data_r;
  assign out_two_byte_write = out_two_r;
  assign out_row_last       = out_row_last_r;
  assign out_frame_last     = out_frame_last_r;

  a_frame_last_is_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_last_r |-> out_row_last_r)
    else $error("frame end without row end");

  a_rgb565_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_two_r |-> out_data_r[31:16] == 16'd0)
    else $error("rgb565 write has nonzero upper half");

  a_row_end_wraps_column: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && row_end |=> col_r == '0)
    else $error("column not cleared after row end");

  a_frame_end_wraps_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && frame_end |=> row_r == '0 && col_r == '0)
    else $error("position not cleared after frame end");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty result register");

endmodule

// ----- bench/framebuffer_pixel_writer_tb.sv -----
// framebuffer_pixel_writer_tb: self-checking bench for pixel conversion and write address generation
`timescale 1ns / 1ps

module framebuffer_pixel_writer_tb;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned PHASES = 12;
  localparam int unsigned ITEMS_PER_PHASE = 42;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] data;
    logic        two_byte;
    logic        row_last;
    logic        frame_last;
  } pixel_write_t;

  typedef struct {
    bit                   is_reg;
    fbpw_pkg::reg_index_t idx;
    logic [31:0]          value;
    bit                   typed;
    pixel_write_t         want;
  } directed_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_source_pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_write_address;
  logic [31:0] out_write_data;
  logic out_two_byte_write;
  logic out_row_last;
  logic out_frame_last;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [fbpw_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [fbpw_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [fbpw_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // register shadow
  logic [1:0]  fb_format = fbpw_pkg::FMT_RGB565;
  logic        src_565 = 1'b0;
  logic [12:0] width_reg = 13'd1;
  logic [12:0] height_reg = 13'd1;
  logic [16:0] stride_reg = 17'd4;
  logic [31:0] offset_reg = '0;
  logic [31:0] base_reg = '0;

  // raster position
  logic [11:0] col_pos = '0;
  logic [11:0] row_pos = '0;
  logic [31:0] row_addr = '0;

  pixel_write_t pending_writes[$];
  directed_row_t directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  bit hold_request = 1'b0;

  framebuffer_pixel_writer #(.MAX_DIMENSION(MAX_DIMENSION)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_source_pixel(in_source_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_write_address(out_write_address), .out_write_data(out_write_data),
    .out_two_byte_write(out_two_byte_write), .out_row_last(out_row_last),
    .out_frame_last(out_frame_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return 32'(v);
  endfunction

  function automatic pixel_write_t predict_write(input logic [31:0] pix);
    int unsigned w;
    int unsigned h;
    logic to565;
    logic argb_out;
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    pixel_write_t res;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    to565 = (fb_format == fbpw_pkg::FMT_RGB565);
    argb_out = (fb_format >= fbpw_pkg::FMT_ARGB8888);
    if (col_pos == 0 && row_pos == 0) row_addr = base_reg + offset_reg;
    res.addr = row_addr + (32'(col_pos) << (to565 ? 1 : 2));
    if (src_565) begin
      r5 = pix[15:11];
      g6 = pix[10:5];
      b5 = pix[4:0];
      if (to565) res.data = {16'h0000, pix[15:0]};
      else res.data = (argb_out ? fbpw_pkg::ALPHA_MASK : 32'h0)
                    | {8'h00, r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
    end else begin
      if (to565) res.data = {16'h0000, pix[23:19], pix[15:10], pix[7:3]};
      else if (!argb_out) res.data = pix & fbpw_pkg::COLOR_MASK;
      else res.data = pix;
    end
    res.two_byte = to565;
    res.row_last = (int'(col_pos) + 1 >= w);
    res.frame_last = res.row_last && (int'(row_pos) + 1 >= h);
    if (res.row_last) begin
      col_pos = '0;
      if (res.frame_last) begin
        row_pos = '0;
      end else begin
        row_pos++;
        row_addr += 32'(stride_reg);
      end
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  task automatic write_reg(input fbpw_pkg::reg_index_t idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      fbpw_pkg::REG_DEST_FORMAT:      fb_format = value[1:0];
      fbpw_pkg::REG_SOURCE_IS_RGB565: src_565 = value[0];
      fbpw_pkg::REG_FRAME_WIDTH:      width_reg = value[12:0];
      fbpw_pkg::REG_FRAME_HEIGHT:     height_reg = value[12:0];
      fbpw_pkg::REG_ROW_STRIDE:       stride_reg = value[16:0];
      fbpw_pkg::REG_VISIBLE_OFFSET:   offset_reg = value;
      fbpw_pkg::REG_FRAME_BASE:       base_reg = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [31:0] pix, input bit typed, input pixel_write_t want);
    pixel_write_t predicted;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_source_pixel <= pix;
    do @(posedge clk); while (in_stall);
    predicted = predict_write(pix);
    pending_writes.push_back(typed ? want : predicted);
  endtask

  task automatic drain_writes();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic void add_reg(input fbpw_pkg::reg_index_t idx, input logic [31:0] value);
    directed_row_t row;
    row.is_reg = 1'b1;
    row.idx = idx;
    row.value = value;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_pixel(input logic [31:0] pix, input bit typed,
                                    input logic [31:0] addr, input logic [31:0] data,
                                    input logic two_byte, input logic row_last,
                                    input logic frame_last);
    directed_row_t row;
    row.is_reg = 1'b0;
    row.idx = fbpw_pkg::REG_DEST_FORMAT;
    row.value = pix;
    row.typed = typed;
    row.want = '{addr, data, two_byte, row_last, frame_last};
    directed_rows.push_back(row);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    pixel_write_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: address %h data %h",
                   out_write_address, out_write_data);
      end else begin
        want = pending_writes.pop_front();
        check_field("write_address", want.addr, out_write_address);
        check_field("write_data", want.data, out_write_data);
        check_field("two_byte_write", 32'(want.two_byte), 32'(out_two_byte_write));
        check_field("row_last", 32'(want.row_last), 32'(out_row_last));
        check_field("frame_last", 32'(want.frame_last), 32'(out_frame_last));
      end
    end
  end

  // receiver stall bursts and the long hold-off
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        n = LONG_HOLD_CYCLES;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
      end else begin
        n = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] stride;
    directed_row_t row;

    // reset defaults: rgb565 out, argb source, 1x1 frame at address 0; then the 32-bit and unused format codes
    add_pixel(32'hffff_ffff, 1, 32'h0, 32'h0000_ffff, 1, 1, 1);
    add_pixel(32'h0000_0000, 1, 32'h0, 32'h0000_0000, 1, 1, 1);
    add_reg(fbpw_pkg::REG_DEST_FORMAT, 32'(fbpw_pkg::FMT_ARGB8888));
    add_pixel(32'h1234_5678, 1, 32'h0, 32'h1234_5678, 0, 1, 1);
    add_reg(fbpw_pkg::REG_DEST_FORMAT, 32'(fbpw_pkg::FMT_XRGB8888));
    add_pixel(32'hffff_ffff, 1, 32'h0, 32'h00ff_ffff, 0, 1, 1);
    add_reg(fbpw_pkg::REG_DEST_FORMAT, 32'(FMT_UNUSED));
    add_pixel(32'ha5a5_a5a5, 1, 32'h0, 32'ha5a5_a5a5, 0, 1, 1);
    // rgb565 source, upper half ignored
    add_reg(fbpw_pkg::REG_SOURCE_IS_RGB565, 32'd1);
    add_reg(fbpw_pkg::REG_DEST_FORMAT, 32'(fbpw_pkg::FMT_ARGB8888));
    add_pixel(32'hffff_0000, 1, 32'h0, 32'hff00_0000, 0, 1, 1);
    add_pixel(32'h0000_ffff, 1, 32'h0, 32'hffff_ffff, 0, 1, 1);
    add_reg(fbpw_pkg::REG_DEST_FORMAT, 32'(fbpw_pkg::FMT_XRGB8888));
    add_pixel(32'h0001_ffff, 1, 32'h0, 32'h00ff_ffff, 0, 1, 1);
    add_reg(fbpw_pkg::REG_DEST_FORMAT, 32'(fbpw_pkg::FMT_RGB565));
    add_pixel(32'habcd_1234, 1, 32'h0, 32'h0000_1234, 1, 1, 1);
    // zero size, base plus offset at the top of the address space
    add_reg(fbpw_pkg::REG_SOURCE_IS_RGB565, 32'd0);
    add_reg(fbpw_pkg::REG_FRAME_BASE, 32'hffff_fff0);
    add_reg(fbpw_pkg::REG_VISIBLE_OFFSET, 32'h0000_000c);
    add_reg(fbpw_pkg::REG_FRAME_WIDTH, 32'd0);
    add_reg(fbpw_pkg::REG_FRAME_HEIGHT, 32'd0);
    add_pixel(32'h00f8_0000, 1, 32'hffff_fffc, 32'h0000_f800, 1, 1, 1);
    // odd stride, address wrap
    add_reg(fbpw_pkg::REG_FRAME_WIDTH, 32'd3);
    add_reg(fbpw_pkg::REG_FRAME_HEIGHT, 32'd2);
    add_reg(fbpw_pkg::REG_ROW_STRIDE, 32'd1);
    add_pixel(32'h0000_fc00, 0, '0, '0, 0, 0, 0);
    add_pixel(32'h0000_00f8, 0, '0, '0, 0, 0, 0);
    add_pixel(32'h00ff_0000, 0, '0, '0, 0, 0, 0);
    add_pixel(32'h8000_0001, 0, '0, '0, 0, 0, 0);
    add_pixel(32'h7fff_fffe, 0, '0, '0, 0, 0, 0);
    add_pixel(32'h5555_aaaa, 0, '0, '0, 0, 0, 0);
    // oversize height, max stride, then shrink mid-frame
    add_reg(fbpw_pkg::REG_ROW_STRIDE, 32'h0001_ffff);
    add_reg(fbpw_pkg::REG_FRAME_WIDTH, 32'd5);
    add_reg(fbpw_pkg::REG_FRAME_HEIGHT, 32'd8191);
    add_pixel(32'h0102_0304, 0, '0, '0, 0, 0, 0);
    add_pixel(32'h0506_0708, 0, '0, '0, 0, 0, 0);
    add_reg(fbpw_pkg::REG_FRAME_WIDTH, 32'd1);
    add_pixel(32'h090a_0b0c, 0, '0, '0, 0, 0, 0);
    add_reg(fbpw_pkg::REG_ROW_STRIDE, 32'd0);
    add_pixel(32'h0d0e_0f10, 0, '0, '0, 0, 0, 0);
    add_pixel(32'h1112_1314, 0, '0, '0, 0, 0, 0);
    add_reg(fbpw_pkg::REG_FRAME_HEIGHT, 32'd1);
    add_pixel(32'h1516_1718, 0, '0, '0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg) begin
        drain_writes();
        write_reg(row.idx, row.value);
      end else begin
        send_pixel(row.value, row.typed, row.want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_writes();
      gaps_on = (phase < PHASES - 2);
      stall_on = gaps_on;
      case (phase)
        0: begin w = 4096; h = 8191; end
        1: begin w = 1; h = 4096; end
        2: begin w = 8191; h = 0; end
        default: begin w = $urandom_range(0, 6); h = $urandom_range(0, 4); end
      endcase
      if (phase == 1) stride = 32'h0001_ffff;
      else if ($urandom_range(0, 1) == 0) stride = $urandom_range(0, 32'h0001_ffff);
      else stride = w * 4;
      write_reg(fbpw_pkg::REG_DEST_FORMAT, $urandom_range(0, 3));
      write_reg(fbpw_pkg::REG_SOURCE_IS_RGB565, $urandom_range(0, 1));
      write_reg(fbpw_pkg::REG_FRAME_WIDTH, w);
      write_reg(fbpw_pkg::REG_FRAME_HEIGHT, h);
      write_reg(fbpw_pkg::REG_ROW_STRIDE, stride);
      write_reg(fbpw_pkg::REG_VISIBLE_OFFSET, $urandom);
      write_reg(fbpw_pkg::REG_FRAME_BASE, $urandom);
      if (phase == 3) begin
        gaps_on = 1'b0;
        hold_request = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (phase == 6 && i == ITEMS_PER_PHASE / 2) drain_writes();
        send_pixel($urandom, 0, '0);
      end
    end

    drain_writes();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
